// ===== rtl/sukl_pkg.sv =====
package sukl_pkg;

   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_KEY_WIDTH   = 32;
   localparam int KEY_FIELD_WIDTH = 32;
   localparam int COUNT_WIDTH     = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_DUMP   = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic [1:0]                        op;
      logic signed [KEY_FIELD_WIDTH-1:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]                        status;
      logic signed [KEY_FIELD_WIDTH-1:0] key_out;
      logic [COUNT_WIDTH-1:0]            count;
      logic                              last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE,
      S_DUMP
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_COMPARE,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_cmd_type;

endpackage

// ===== rtl/sukl_cell.sv =====
module sukl_cell #(
   parameter int KEY_WIDTH = sukl_pkg::DEF_KEY_WIDTH
) (
   input  logic                        clock,
   input  sukl_pkg::cell_cmd_type      cmd,
   input  logic signed [KEY_WIDTH-1:0] op_key,
   input  logic signed [KEY_WIDTH-1:0] head_key,
   input  logic                        valid,
   input  logic signed [KEY_WIDTH-1:0] prev_key,
   input  logic                        prev_lt,
   input  logic signed [KEY_WIDTH-1:0] next_key,
   input  logic                        next_valid,
   output logic signed [KEY_WIDTH-1:0] key,
   output logic                        lt,
   output logic                        eq
);

   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic                        lt_ff, lt_in;
   logic                        eq_ff, eq_in;

   always_comb begin
      key_in = key_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      unique case (cmd)
         sukl_pkg::CELL_COMPARE: begin
            lt_in = valid && (key_ff < op_key);
            eq_in = valid && (key_ff == op_key);
         end
         sukl_pkg::CELL_INSERT: begin
            if (!lt_ff) begin
               key_in = prev_lt ? op_key : prev_key;
            end
         end
         sukl_pkg::CELL_DELETE: begin
            if (!lt_ff) begin
               key_in = next_key;
            end
         end
         sukl_pkg::CELL_ROTATE: begin
            if (valid) begin
               key_in = next_valid ? next_key : head_key;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key = key_ff;
   assign lt  = lt_ff;
   assign eq  = eq_ff;

endmodule

// ===== rtl/sorted_unique_key_list.sv =====
// channel | ports                            | transfer when
// --------+----------------------------------+------------------------
// request | req_valid, req_ready, req_data   | req_valid & req_ready
// result  | rsp_valid, rsp_ready, rsp_data   | rsp_valid & rsp_ready
//
// Insert, delete and search go through capture, compare in every cell,
// then shift the cell row and load the result register.
// A dump then rotates the row one cell a cycle past cell 0 unless stalled.
// One item at a time; the result register lets the next item in while the
// last result waits. A stalled result holds the row and the update or dump state.
// Synchronous reset empties the list; cell contents are not cleared.
module sorted_unique_key_list #(
   parameter int CAPACITY  = sukl_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = sukl_pkg::DEF_KEY_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sukl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sukl_pkg::rsp_type rsp_data
);

   localparam int FW = $clog2(CAPACITY + 1);

   sukl_pkg::state_type    state_ff, state_in;
   sukl_pkg::cell_cmd_type cell_cmd;

   logic [1:0]                  op_ff;
   logic signed [KEY_WIDTH-1:0] key_ff;
   logic [FW-1:0]               fill_ff, fill_in;
   logic [FW-1:0]               dump_cnt_ff, dump_cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sukl_pkg::rsp_type           rsp_data_ff, rsp_next;
   logic                        load;

   logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0]         lt_vec, eq_vec, valid_vec;

   logic hit, out_free, dump_last;

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_WIDTH-1:0] prev_key, next_key;
      logic                        prev_lt, next_valid;

      assign valid_vec[i] = (FW'(i) < fill_ff);

      if (i == 0) begin : g_head
         assign prev_key = key_ff;
         assign prev_lt  = 1'b1;
      end else begin : g_body
         assign prev_key = cell_key[i-1];
         assign prev_lt  = lt_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_key   = key_ff;
         assign next_valid = 1'b0;
      end else begin : g_mid
         assign next_key   = cell_key[i+1];
         assign next_valid = valid_vec[i+1];
      end

      sukl_cell #(
         .KEY_WIDTH(KEY_WIDTH)
      ) u_cell (
         .clock     (clock),
         .cmd       (cell_cmd),
         .op_key    (key_ff),
         .head_key  (cell_key[0]),
         .valid     (valid_vec[i]),
         .prev_key  (prev_key),
         .prev_lt   (prev_lt),
         .next_key  (next_key),
         .next_valid(next_valid),
         .key       (cell_key[i]),
         .lt        (lt_vec[i]),
         .eq        (eq_vec[i])
      );
   end

   assign hit       = |eq_vec;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dump_last = (dump_cnt_ff == fill_ff - FW'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sukl_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = sukl_pkg::S_COMPARE;
            end
         end
         sukl_pkg::S_COMPARE: begin
            state_in = sukl_pkg::S_UPDATE;
         end
         sukl_pkg::S_UPDATE: begin
            if (out_free) begin
               if (op_ff == sukl_pkg::OP_DUMP && fill_ff != '0) begin
                  state_in = sukl_pkg::S_DUMP;
               end else begin
                  state_in = sukl_pkg::S_IDLE;
               end
            end
         end
         sukl_pkg::S_DUMP: begin
            if (out_free && dump_last) begin
               state_in = sukl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sukl_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready        = 1'b0;
      cell_cmd         = sukl_pkg::CELL_HOLD;
      load             = 1'b0;
      fill_in          = fill_ff;
      dump_cnt_in      = dump_cnt_ff;
      rsp_next.status  = sukl_pkg::ST_OK;
      rsp_next.key_out = '0;
      rsp_next.last    = 1'b1;
      unique case (state_ff)
         sukl_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         sukl_pkg::S_COMPARE: begin
            cell_cmd    = sukl_pkg::CELL_COMPARE;
            dump_cnt_in = '0;
         end
         sukl_pkg::S_UPDATE: begin
            if (out_free) begin
               priority if (op_ff == sukl_pkg::OP_DUMP) begin
                  if (fill_ff == '0) begin
                     load            = 1'b1;
                     rsp_next.status = sukl_pkg::ST_EMPTY;
                  end
               end else if (op_ff != sukl_pkg::OP_INSERT && fill_ff == '0) begin
                  load            = 1'b1;
                  rsp_next.status = sukl_pkg::ST_EMPTY;
               end else if (op_ff == sukl_pkg::OP_INSERT) begin
                  load = 1'b1;
                  priority if (hit) begin
                     rsp_next.status = sukl_pkg::ST_DUP;
                  end else if (fill_ff == FW'(CAPACITY)) begin
                     rsp_next.status = sukl_pkg::ST_FULL;
                  end else begin
                     cell_cmd = sukl_pkg::CELL_INSERT;
                     fill_in  = fill_ff + FW'(1);
                  end
               end else if (op_ff == sukl_pkg::OP_DELETE) begin
                  load = 1'b1;
                  if (hit) begin
                     cell_cmd = sukl_pkg::CELL_DELETE;
                     fill_in  = fill_ff - FW'(1);
                  end else begin
                     rsp_next.status = sukl_pkg::ST_NOTFOUND;
                  end
               end else begin
                  load = 1'b1;
                  if (hit) begin
                     rsp_next.key_out = sukl_pkg::KEY_FIELD_WIDTH'($unsigned(key_ff));
                  end else begin
                     rsp_next.status = sukl_pkg::ST_NOTFOUND;
                  end
               end
            end
         end
         sukl_pkg::S_DUMP: begin
            if (out_free) begin
               load             = 1'b1;
               cell_cmd         = sukl_pkg::CELL_ROTATE;
               rsp_next.key_out = sukl_pkg::KEY_FIELD_WIDTH'($unsigned(cell_key[0]));
               rsp_next.last    = dump_last;
               dump_cnt_in      = dump_cnt_ff + FW'(1);
            end
         end
         default: begin
         end
      endcase
      rsp_next.count = sukl_pkg::COUNT_WIDTH'(fill_in);
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sukl_pkg::S_IDLE;
         fill_ff      <= '0;
         dump_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dump_cnt_ff  <= dump_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_data.op;
         key_ff <= $signed(KEY_WIDTH'($unsigned(req_data.key)));
      end
      if (load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/sukl_checker.sv =====
module sukl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input sukl_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sukl_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // a waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed or dropped while waiting");

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   // only ok results carry a key or continue a dump
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != sukl_pkg::ST_OK |-> rsp_data.last
         && rsp_data.key_out == '0)
      else $error("error result not single or carries a key");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sorted_unique_key_list sukl_checker u_checker (.*);

// ===== bench/sorted_unique_key_list_checker.sv =====
`timescale 1ns / 1ps

module sorted_unique_key_list_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  sukl_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  sukl_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                outstanding
);

   localparam int LIST_DEPTH = sukl_pkg::DEF_CAPACITY;
   localparam int KW         = sukl_pkg::KEY_FIELD_WIDTH;

   logic signed [KW-1:0] keys [LIST_DEPTH];
   int unsigned          stored;
   sukl_pkg::rsp_type    due_results [$];

   function automatic sukl_pkg::rsp_type make_rsp(logic [2:0] status,
                                                  logic signed [KW-1:0] key,
                                                  logic last);
      sukl_pkg::rsp_type r;
      r.status  = status;
      r.key_out = key;
      r.count   = stored[sukl_pkg::COUNT_WIDTH-1:0];
      r.last    = last;
      return r;
   endfunction

   task automatic apply_list_op(sukl_pkg::req_type item);
      int                   pos;
      logic                 hit;
      logic signed [KW-1:0] key;
      key = $signed(item.key);
      if (item.op == sukl_pkg::OP_DUMP) begin
         if (stored == 0) begin
            due_results.push_back(make_rsp(sukl_pkg::ST_EMPTY, '0, 1'b1));
         end else begin
            for (int i = 0; i < stored; i++)
               due_results.push_back(make_rsp(sukl_pkg::ST_OK, keys[i], i == stored - 1));
         end
         return;
      end
      if (item.op != sukl_pkg::OP_INSERT && stored == 0) begin
         due_results.push_back(make_rsp(sukl_pkg::ST_EMPTY, '0, 1'b1));
         return;
      end
      pos = 0;
      while (pos < stored && keys[pos] < key)
         pos++;
      hit = (pos < stored) && (keys[pos] == key);
      case (item.op)
         sukl_pkg::OP_INSERT: begin
            if (hit) begin
               due_results.push_back(make_rsp(sukl_pkg::ST_DUP, '0, 1'b1));
            end else if (stored >= LIST_DEPTH) begin
               due_results.push_back(make_rsp(sukl_pkg::ST_FULL, '0, 1'b1));
            end else begin
               for (int i = stored; i > pos; i--)
                  keys[i] = keys[i-1];
               keys[pos] = key;
               stored++;
               due_results.push_back(make_rsp(sukl_pkg::ST_OK, '0, 1'b1));
            end
         end
         sukl_pkg::OP_DELETE: begin
            if (!hit) begin
               due_results.push_back(make_rsp(sukl_pkg::ST_NOTFOUND, '0, 1'b1));
            end else begin
               for (int i = pos; i + 1 < stored; i++)
                  keys[i] = keys[i+1];
               stored--;
               due_results.push_back(make_rsp(sukl_pkg::ST_OK, '0, 1'b1));
            end
         end
         default: begin
            if (hit)
               due_results.push_back(make_rsp(sukl_pkg::ST_OK, keys[pos], 1'b1));
            else
               due_results.push_back(make_rsp(sukl_pkg::ST_NOTFOUND, '0, 1'b1));
         end
      endcase
   endtask

   always @(posedge clock) begin
      sukl_pkg::rsp_type want;
      if (reset) begin
         stored     = 0;
         mismatches = 0;
         due_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected transfer: status %0d key_out %0d count %0d last %0d",
                           $time, rsp_data.status, $signed(rsp_data.key_out),
                           rsp_data.count, rsp_data.last);
            end else begin
               want = due_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.key_out !== want.key_out ||
                   rsp_data.count !== want.count || rsp_data.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t: mismatch: expected status %0d key_out %0d count %0d last %0d",
                            $time, want.status, $signed(want.key_out), want.count,
                            want.last);
                     $display(", got status %0d key_out %0d count %0d last %0d",
                              rsp_data.status, $signed(rsp_data.key_out),
                              rsp_data.count, rsp_data.last);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            apply_list_op(req_data);
      end
      outstanding = due_results.size();
   end

endmodule

// ===== bench/sorted_unique_key_list_test.sv =====
`timescale 1ns / 1ps

module sorted_unique_key_list_test;

   localparam int KW        = sukl_pkg::KEY_FIELD_WIDTH;
   localparam int POOL_SIZE = 24;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   sukl_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   sukl_pkg::rsp_type rsp_data;
   int                mismatches;
   int                outstanding;
   bit                tail_phase;

   logic signed [KW-1:0] key_pool [POOL_SIZE];

   sorted_unique_key_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sorted_unique_key_list_checker list_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic send_op(logic [1:0] op, logic signed [KW-1:0] key);
      sukl_pkg::req_type item;
      item.op  = op;
      item.key = key;
      if (!tail_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   function automatic logic signed [KW-1:0] pick_key();
      if ($urandom_range(0, 99) < 85)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         if (!tail_phase && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   initial begin
      int         mode;
      int         roll;
      int         ins_lim;
      int         del_lim;
      int         srch_lim;
      logic [1:0] op;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      tail_phase = 1'b0;
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = '0;
      key_pool[3] = -1;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_op(sukl_pkg::OP_DUMP,   $urandom);
      send_op(sukl_pkg::OP_DELETE, 7);
      send_op(sukl_pkg::OP_SEARCH, 7);
      send_op(sukl_pkg::OP_INSERT, 0);
      send_op(sukl_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_op(sukl_pkg::OP_INSERT, 32'sh8000_0000);
      send_op(sukl_pkg::OP_INSERT, -1);
      send_op(sukl_pkg::OP_INSERT, 1);
      send_op(sukl_pkg::OP_INSERT, 0);
      send_op(sukl_pkg::OP_SEARCH, 32'sh8000_0000);
      send_op(sukl_pkg::OP_SEARCH, 32'sh7fff_ffff);
      send_op(sukl_pkg::OP_SEARCH, 2);
      send_op(sukl_pkg::OP_DELETE, 2);
      send_op(sukl_pkg::OP_DUMP,   $urandom);
      send_op(sukl_pkg::OP_DELETE, 32'sh7fff_ffff);
      send_op(sukl_pkg::OP_SEARCH, 32'sh7fff_ffff);
      send_op(sukl_pkg::OP_DELETE, 32'sh8000_0000);
      send_op(sukl_pkg::OP_DELETE, 0);
      send_op(sukl_pkg::OP_DELETE, -1);
      send_op(sukl_pkg::OP_DELETE, 1);
      send_op(sukl_pkg::OP_SEARCH, 1);
      send_op(sukl_pkg::OP_DUMP,   $urandom);
      send_op(sukl_pkg::OP_INSERT, 32'sh5555_5555);
      send_op(sukl_pkg::OP_INSERT, 32'shaaaa_aaaa);

      // segments lean towards filling, draining or mixed traffic
      for (int n = 0; n < 300; n++) begin
         if (n % 25 == 0) begin
            mode = $urandom_range(0, 2);
            repeat (4) key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
         end
         if (n == 260)
            tail_phase = 1'b1;
         case (mode)
            0:       begin ins_lim = 60; del_lim = 75; srch_lim = 90; end
            1:       begin ins_lim = 15; del_lim = 75; srch_lim = 90; end
            default: begin ins_lim = 30; del_lim = 55; srch_lim = 90; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < ins_lim)
            op = sukl_pkg::OP_INSERT;
         else if (roll < del_lim)
            op = sukl_pkg::OP_DELETE;
         else if (roll < srch_lim)
            op = sukl_pkg::OP_SEARCH;
         else
            op = sukl_pkg::OP_DUMP;
         send_op(op, pick_key());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sorted_unique_key_list.f =====
rtl/sukl_pkg.sv
rtl/sukl_cell.sv
rtl/sorted_unique_key_list.sv
rtl/sukl_checker.sv
bench/sorted_unique_key_list_checker.sv
bench/sorted_unique_key_list_test.sv
